[rtl/core/mlc_pkg.sv]
// Package with opcodes, constants and bit-interleave helpers for the Morton code unit.
`timescale 1ns / 1ps

package mlc_pkg;

  // Operation codes carried in the opcode field.
  localparam logic [3:0] OP_ENC3      = 4'd0;
  localparam logic [3:0] OP_ENC2      = 4'd1;
  localparam logic [3:0] OP_DEC3      = 4'd2;
  localparam logic [3:0] OP_DEC2      = 4'd3;
  localparam logic [3:0] OP_ENC3_LOD  = 4'd4;
  localparam logic [3:0] OP_ENC2_LOD  = 4'd5;
  localparam logic [3:0] OP_DEC3_LOD  = 4'd6;
  localparam logic [3:0] OP_DEC2_LOD  = 4'd7;
  localparam logic [3:0] OP_NEIGH2    = 4'd8;
  localparam logic [3:0] OP_FLIP2     = 4'd9;
  localparam logic [3:0] OP_LEVEL     = 4'd10;

  // Code constants.
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0] LOD_MARK    = 32'h8000_0000;
  localparam logic [31:0] KEEP30      = 32'h3FFF_FFFF;
  localparam logic [31:0] MASK_X      = 32'h5555_5555;
  localparam logic [31:0] MASK_Y      = 32'hAAAA_AAAA;
  localparam logic [3:0]  LOD3_MAX    = 4'd10;

  // Final step applied in the last stage.
  typedef enum logic [1:0] {
    FIN_PASS,
    FIN_LOD3,
    FIN_LOD2
  } mlc_fin_e;

  // First stage register contents.
  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  lod;
    logic [15:0] off_x;
    logic [15:0] off_y;
    logic [31:0] code;
    logic [31:0] strip;
    logic [9:0]  cx3;
    logic [9:0]  cy3;
    logic [9:0]  cz3;
    logic [15:0] cx2;
    logic [15:0] cy2;
    logic [4:0]  level;
  } mlc_s1_t;

  // Second stage register contents.
  typedef struct packed {
    mlc_fin_e    fin;
    logic [3:0]  lod;
    logic [31:0] base;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [4:0]  level;
    logic        ok;
  } mlc_s2_t;

  // Spread ten bits to every third position.
  function automatic logic [29:0] spread10_3(input logic [9:0] v);
    logic [29:0] r;
    r = '0;
    for (int i = 0; i < 10; i++) begin
      r[3*i] = v[i];
    end
    return r;
  endfunction

  // Spread sixteen bits to every second position.
  function automatic logic [31:0] spread16_2(input logic [15:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i] = v[i];
    end
    return r;
  endfunction

  // Collect every third bit, ten bits.
  function automatic logic [9:0] gather10_3(input logic [31:0] v);
    logic [9:0] r;
    for (int i = 0; i < 10; i++) begin
      r[i] = v[3*i];
    end
    return r;
  endfunction

  // Collect every second bit, sixteen bits.
  function automatic logic [15:0] gather16_2(input logic [31:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[2*i];
    end
    return r;
  endfunction

  // Leading zeros of one byte, 0 to 8.
  function automatic logic [3:0] lzc8(input logic [7:0] v);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zeros of a 32-bit word, 0 to 32, built from byte counts.
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    if (v[31:24] != 8'd0) begin
      n = {2'b00, lzc8(v[31:24])};
    end else if (v[23:16] != 8'd0) begin
      n = 6'd8 + {2'b00, lzc8(v[23:16])};
    end else if (v[15:8] != 8'd0) begin
      n = 6'd16 + {2'b00, lzc8(v[15:8])};
    end else if (v[7:0] != 8'd0) begin
      n = 6'd24 + {2'b00, lzc8(v[7:0])};
    end else begin
      n = 6'd32;
    end
    return n;
  endfunction

endpackage

[rtl/core/morton_lod_code_unit.sv]
// Top level of the Morton code unit: three-stage pipeline with stream handshakes.
`timescale 1ns / 1ps
// Pipeline: three register stages, namely stage 1, stage 2 and the output register.
// Throughput: one item per cycle while the output is not stalled; each of the three
// stages holds one item and advances whenever the stage after it is empty or moving.
// Reset clears the stage valid bits only; payload registers are not reset.
// The output register doubles as the skid stage, so input keeps flowing while
// a result waits as long as an earlier stage is free.

module morton_lod_code_unit
  import mlc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: opcode[3:0], coord_x[17:0], coord_y[17:0], coord_z[17:0],
  // code_in[31:0], lod[3:0], offset_x[15:0], offset_y[15:0], two zero bits.
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: code_out[31:0], x_out[15:0], y_out[15:0], z_out[15:0],
  // level_out[4:0], valid_res, two zero bits.
  output logic [87:0]  m_axis_tdata_o
);

  // Input field slices.
  logic [3:0]         opcode;
  logic signed [17:0] coord_x;
  logic signed [17:0] coord_y;
  logic signed [17:0] coord_z;
  logic [31:0]        code_in;
  logic [3:0]         lod;
  logic [15:0]        offset_x;
  logic [15:0]        offset_y;

  assign opcode   = s_axis_tdata_i[3:0];
  assign coord_x  = s_axis_tdata_i[21:4];
  assign coord_y  = s_axis_tdata_i[39:22];
  assign coord_z  = s_axis_tdata_i[57:40];
  assign code_in  = s_axis_tdata_i[89:58];
  assign lod      = s_axis_tdata_i[93:90];
  assign offset_x = s_axis_tdata_i[109:94];
  assign offset_y = s_axis_tdata_i[125:110];

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic en1, en2, en3;

  assign en3 = !s3_valid_q || m_axis_tready_i;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign s_axis_tready_o = en1;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp coordinates to cells, strip the level marker, count zeros.
  // ---------------------------------------------------------------------
  mlc_s1_t    s1_d, s1_q;
  logic [5:0] sh3_in, sh2_in;
  logic [5:0] lz;

  assign sh3_in = {2'b00, lod} + {1'b0, lod, 1'b0};
  assign sh2_in = {1'b0, lod, 1'b0};
  assign lz     = lzc32(code_in);

  always_comb begin
    s1_d       = '0;
    s1_d.op    = opcode;
    s1_d.lod   = lod;
    s1_d.off_x = offset_x;
    s1_d.off_y = offset_y;
    s1_d.code  = code_in;
    s1_d.level = lz[5:1];

    // A 3D cell is the Q2.16 value scaled to 1024 steps and clamped.
    s1_d.cx3 = coord_x[17] ? 10'd0 : (coord_x[16] ? 10'd1023 : coord_x[15:6]);
    s1_d.cy3 = coord_y[17] ? 10'd0 : (coord_y[16] ? 10'd1023 : coord_y[15:6]);
    s1_d.cz3 = coord_z[17] ? 10'd0 : (coord_z[16] ? 10'd1023 : coord_z[15:6]);
    // A 2D cell is the raw value clamped to 16 bits.
    s1_d.cx2 = coord_x[17] ? 16'd0 : (coord_x[16] ? 16'hFFFF : coord_x[15:0]);
    s1_d.cy2 = coord_y[17] ? 16'd0 : (coord_y[16] ? 16'hFFFF : coord_y[15:0]);

    // Remove the level marker by shifting it out of the top.
    unique case (opcode)
      OP_DEC3_LOD: s1_d.strip = (code_in << sh3_in) & KEEP30;
      OP_DEC2_LOD, OP_NEIGH2, OP_FLIP2: begin
        s1_d.strip = ((code_in << sh2_in) & KEEP30) << 2;
      end
      default: s1_d.strip = code_in;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: interleave, de-interleave, neighbor step and mirror.
  // ---------------------------------------------------------------------
  mlc_s2_t            s2_d, s2_q;
  logic [29:0]        enc3;
  logic [31:0]        enc2;
  logic [15:0]        gx, gy;
  logic signed [33:0] step_x, step_y, nx, ny;
  logic [4:0]         scale;
  logic               bad3;
  logic               in_grid;

  assign enc3  = spread10_3(s1_q.cx3) | (spread10_3(s1_q.cy3) << 1)
               | (spread10_3(s1_q.cz3) << 2);
  assign enc2  = spread16_2(s1_q.cx2) | (spread16_2(s1_q.cy2) << 1);
  assign gx    = gather16_2(s1_q.strip);
  assign gy    = gather16_2(s1_q.strip >> 1);
  assign bad3  = s1_q.lod > LOD3_MAX;
  assign scale = {1'b0, s1_q.lod} + 5'd1;

  // Offsets are scaled by two to the level plus one, without wrapping.
  assign step_x  = $signed({{18{s1_q.off_x[15]}}, s1_q.off_x}) <<< scale;
  assign step_y  = $signed({{18{s1_q.off_y[15]}}, s1_q.off_y}) <<< scale;
  assign nx      = step_x + $signed({18'd0, gx});
  assign ny      = step_y + $signed({18'd0, gy});
  assign in_grid = (nx[33:16] == 18'd0) && (ny[33:16] == 18'd0);

  always_comb begin
    s2_d       = '0;
    s2_d.fin   = FIN_PASS;
    s2_d.lod   = s1_q.lod;
    s2_d.ok    = 1'b1;

    unique case (s1_q.op)
      OP_ENC3: s2_d.base = {2'b00, enc3};
      OP_ENC2: s2_d.base = enc2;
      OP_ENC3_LOD: begin
        if (bad3) begin
          s2_d.ok   = 1'b0;
          s2_d.base = ALL_ONES;
        end else begin
          s2_d.base = {2'b00, enc3};
          s2_d.fin  = FIN_LOD3;
        end
      end
      OP_ENC2_LOD: begin
        s2_d.base = enc2;
        s2_d.fin  = FIN_LOD2;
      end
      OP_DEC3, OP_DEC3_LOD: begin
        if (s1_q.op == OP_DEC3_LOD && bad3) begin
          s2_d.ok   = 1'b0;
          s2_d.base = ALL_ONES;
        end else begin
          s2_d.x = {gather10_3(s1_q.strip), 6'd0};
          s2_d.y = {gather10_3(s1_q.strip >> 1), 6'd0};
          s2_d.z = {gather10_3(s1_q.strip >> 2), 6'd0};
        end
      end
      OP_DEC2, OP_DEC2_LOD: begin
        s2_d.x = gx;
        s2_d.y = gy;
      end
      OP_NEIGH2: begin
        if (in_grid) begin
          s2_d.base = spread16_2(nx[15:0]) | (spread16_2(ny[15:0]) << 1);
          s2_d.fin  = FIN_LOD2;
        end else begin
          s2_d.ok   = 1'b0;
          s2_d.base = ALL_ONES;
        end
      end
      OP_FLIP2: begin
        // Which offsets are zero picks the mirror axis.
        priority if (s1_q.off_x == 16'd0 && s1_q.off_y == 16'd0) begin
          s2_d.base = s1_q.code;
        end else if (s1_q.off_x == 16'd0) begin
          s2_d.base = s1_q.strip ^ MASK_Y;
          s2_d.fin  = FIN_LOD2;
        end else if (s1_q.off_y == 16'd0) begin
          s2_d.base = s1_q.strip ^ MASK_X;
          s2_d.fin  = FIN_LOD2;
        end else begin
          s2_d.base = s1_q.strip ^ ALL_ONES;
          s2_d.fin  = FIN_LOD2;
        end
      end
      OP_LEVEL: s2_d.level = s1_q.level;
      default: begin
        s2_d.ok   = 1'b0;
        s2_d.base = ALL_ONES;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: insert the level marker and register the result.
  // ---------------------------------------------------------------------
  logic [31:0] code_d, code_q;
  logic [5:0]  sh3_out, sh2_out;
  logic [15:0] x_q, y_q, z_q;
  logic [4:0]  level_q;
  logic        ok_q;

  assign sh3_out = {2'b00, s2_q.lod} + {1'b0, s2_q.lod, 1'b0};
  assign sh2_out = {1'b0, s2_q.lod, 1'b0};

  always_comb begin
    unique case (s2_q.fin)
      FIN_LOD3: code_d = (s2_q.base | LOD_MARK) >> sh3_out;
      FIN_LOD2: code_d = ((s2_q.base >> 2) | LOD_MARK) >> sh2_out;
      default:  code_d = s2_q.base;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      code_q  <= code_d;
      x_q     <= s2_q.x;
      y_q     <= s2_q.y;
      z_q     <= s2_q.z;
      level_q <= s2_q.level;
      ok_q    <= s2_q.ok;
    end
  end

  assign m_axis_tvalid_o = s3_valid_q;
  assign m_axis_tdata_o  = {2'b00, ok_q, level_q, z_q, y_q, x_q, code_q};

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A rejected result always carries the all-ones code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !ok_q |-> code_q == ALL_ONES)
    else $error("invalid result without all-ones code");

  // A nonzero level only comes from the level operation, which has no code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && level_q != 5'd0 |-> code_q == 32'd0 && ok_q)
    else $error("level result mixed with a code");

  // With every stage full and the output stalled, no input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && s3_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken into a full pipeline");

  // An input transfer always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> s1_valid_q)
    else $error("input transfer lost");

  // A stalled stage keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !en2 |=> s2_valid_q && $stable(s2_q))
    else $error("stalled middle stage changed");

endmodule
